FILE: rtl/pfr_pkg.sv
package pfr_pkg;

    localparam int MAX_TAPS   = 256;
    localparam int MAX_UP     = 16;
    localparam int MAX_DOWN   = 16;
    localparam int HIST_DEPTH = MAX_TAPS + MAX_DOWN;
    localparam int HIST_RAM_DEPTH = 512;
    localparam int HIST_AW    = 9;
    localparam int COEF_AW    = 8;
    localparam int ACC_W      = 41;

    localparam logic [1:0] CFG_UP_FACTOR   = 2'd0;
    localparam logic [1:0] CFG_DOWN_FACTOR = 2'd1;
    localparam logic [1:0] CFG_TAP_COUNT   = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [7:0]         coeff_index;
        logic signed [15:0] coeff_value;
        logic signed [15:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               burst_last;
    } out_item_t;

    typedef struct packed {
        logic               is_sample;
        logic [7:0]         idx;
        logic signed [15:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_OUT,
        ST_ADV
    } back_state_t;

endpackage

FILE: rtl/pfr_ram.sv
module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pfr_front.sv
module pfr_front import pfr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t       q_mem_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       new_cmd;
    logic       push, pop;

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        new_cmd.is_sample = s_data.mode;
        new_cmd.idx       = s_data.coeff_index;
        new_cmd.value     = s_data.mode ? s_data.sample_in : s_data.coeff_value;
    end

    always_comb begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: rtl/pfr_back.sv
module pfr_back import pfr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [4:0] up_factor,
    input  logic [4:0] down_factor,
    input  logic [8:0] tap_count,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    back_state_t state_reg, state_next;

    logic [HIST_AW-1:0]  wptr_reg, wptr_next;
    logic [HIST_AW-1:0]  fill_reg, fill_next;
    logic [3:0]          gc_reg, gc_next;
    logic [3:0]          m_reg, m_next;
    logic [5:0]          phase_reg, phase_next;
    logic [3:0]          j_reg, j_next;
    logic [9:0]          h_reg, h_next;
    logic [HIST_AW-1:0]  pos_reg, pos_next;
    logic                v1_reg, v1_next;
    logic                z1_reg, z1_next;
    logic                v2_reg, v2_next;
    logic signed [31:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic [4:0]  p, q;
    logic [8:0]  taps;
    logic        pop, issue, burst, out_free, last;
    logic [4:0]  gc_inc;
    logic [15:0] coef_rdata, hist_rdata;
    logic signed [15:0] hist_term;
    logic [HIST_AW-1:0] hist_raddr;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-16:0] rshift;
    logic signed [15:0] rsat;

    always_comb begin
        p    = (up_factor == 5'd0) ? 5'd1 :
               (up_factor > 5'(MAX_UP)) ? 5'(MAX_UP) : up_factor;
        q    = (down_factor == 5'd0) ? 5'd1 :
               (down_factor > 5'(MAX_DOWN)) ? 5'(MAX_DOWN) : down_factor;
        taps = (tap_count == 9'd0) ? 9'd1 :
               (tap_count > 9'(MAX_TAPS)) ? 9'(MAX_TAPS) : tap_count;
    end

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pop        = cmd_valid && cmd_ready;
    assign gc_inc     = {1'b0, gc_reg} + 5'd1;
    assign burst      = (gc_inc >= q);
    assign issue      = (state_reg == ST_MAC) && (h_reg < {1'b0, taps});
    assign out_free   = !out_valid_reg || m_ready;
    assign last       = ({1'b0, m_reg} == (p - 5'd1));
    assign hist_raddr = wptr_reg - HIST_AW'(1) - pos_reg;
    assign hist_term  = z1_reg ? 16'sd0 : $signed(hist_rdata);

    pfr_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_coef_ram (
        .aclk  (aclk),
        .we    (pop && !cmd.is_sample),
        .waddr (cmd.idx[COEF_AW-1:0]),
        .wdata (cmd.value),
        .raddr (h_reg[COEF_AW-1:0]),
        .rdata (coef_rdata)
    );

    pfr_ram #(.WIDTH(16), .DEPTH(HIST_RAM_DEPTH)) u_hist_ram (
        .aclk  (aclk),
        .we    (pop && cmd.is_sample),
        .waddr (wptr_reg),
        .wdata (cmd.value),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // round half up, saturate to Q1.15
    always_comb begin
        rsum   = acc_reg + ACC_W'(16384);
        rshift = rsum[ACC_W-1:15];
        if (rshift > (ACC_W-15)'(32767)) begin
            rsat = 16'sh7fff;
        end else if (rshift < -(ACC_W-15)'(32768)) begin
            rsat = -16'sh8000;
        end else begin
            rsat = rshift[15:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && cmd.is_sample && burst) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (!issue && !v1_reg && !v2_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = last ? ST_IDLE : ST_ADV;
                end
            end
            ST_ADV: begin
                if (phase_reg < {1'b0, p}) begin
                    state_next = ST_MAC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        gc_next        = gc_reg;
        m_next         = m_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        h_next         = h_reg;
        pos_next       = pos_reg;
        v1_next        = issue;
        z1_next        = (pos_reg >= fill_reg);
        v2_next        = v1_reg;
        prod_next      = $signed(coef_rdata) * hist_term;
        acc_next       = v2_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && cmd.is_sample) begin
                    wptr_next = wptr_reg + HIST_AW'(1);
                    if (fill_reg != HIST_AW'(HIST_DEPTH)) begin
                        fill_next = fill_reg + HIST_AW'(1);
                    end
                    if (burst) begin
                        gc_next    = 4'd0;
                        m_next     = 4'd0;
                        phase_next = 6'd0;
                        j_next     = 4'd0;
                        h_next     = 10'd0;
                        pos_next   = HIST_AW'(q - 5'd1);
                        acc_next   = '0;
                    end else begin
                        gc_next = gc_inc[3:0];
                    end
                end
            end
            ST_MAC: begin
                if (issue) begin
                    h_next   = h_reg + {5'd0, p};
                    pos_next = pos_reg + HIST_AW'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    out_next.sample_out   = rsat;
                    out_next.burst_last   = last;
                    m_next                = m_reg + 4'd1;
                    phase_next            = phase_reg + {1'b0, q};
                end
            end
            ST_ADV: begin
                if (phase_reg >= {1'b0, p}) begin
                    phase_next = phase_reg - {1'b0, p};
                    j_next     = j_reg + 4'd1;
                end else begin
                    h_next   = {4'd0, phase_reg};
                    pos_next = HIST_AW'(q - 5'd1 - {1'b0, j_reg});
                    acc_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            gc_reg        <= 4'd0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            gc_reg        <= gc_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
        m_reg     <= m_next;
        phase_reg <= phase_next;
        j_reg     <= j_next;
        h_reg     <= h_next;
        pos_reg   <= pos_next;
        z1_reg    <= z1_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/polyphase_fir_resampler.sv
// Rational P/Q polyphase resampler, Q1.15 in and out.
// s_ channel (valid/ready): mode 0 items load one coefficient, mode 1 items
// push one sample. Every Q-th sample closes a group and produces a burst of
// P items on the m_ channel (valid/ready), burst_last set on the final one.
// cfg_wr_en/cfg_index/cfg_wr_data write up_factor, down_factor, tap_count;
// write them only while the block is idle.
// Input items enter a two-entry queue; the back end takes one per cycle when
// idle. A coefficient load or a non-closing sample leaves the back end idle.
// Each burst output runs one shared MAC over every P-th tap of its phase,
// and between outputs the phase steps down by P until it is below P.
// Reset clears the sample history (tracked by a fill count), the group count
// and the queues; coefficients must be loaded before samples are pushed.
// When the receiver stalls, the finished output holds in the output register,
// the back end waits, and the input queue fills, then s_ready drops.
module polyphase_fir_resampler import pfr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [4:0] up_reg;
    logic [4:0] down_reg;
    logic [8:0] taps_reg;
    logic       cmd_valid, cmd_ready;
    cmd_t       cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= 5'd1;
            down_reg <= 5'd1;
            taps_reg <= 9'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_UP_FACTOR:   up_reg   <= cfg_wr_data[4:0];
                CFG_DOWN_FACTOR: down_reg <= cfg_wr_data[4:0];
                CFG_TAP_COUNT:   taps_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    pfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .up_factor   (up_reg),
        .down_factor (down_reg),
        .tap_count   (taps_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pfr_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_UP_FACTOR;
    logic [8:0] cfg_wr_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    polyphase_fir_resampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam int STALL_LIMIT = 20000;
    localparam int COEF_LOADED = 64;

    // model state
    int unsigned up_f = 1, down_f = 1, taps_f = 1;
    logic signed [15:0] coefs [MAX_TAPS];
    logic signed [15:0] hist [HIST_DEPTH];
    int unsigned grp_cnt = 0;

    in_item_t  pending_items [$];
    out_item_t expected_outs [$];
    int errors = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    bit done = 0;

    function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic signed [15:0] round_sat16(longint acc);
        longint r;
        r = (acc + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic resample_item(input in_item_t it);
        int unsigned p, q, t, ph, j, pos;
        longint acc;
        out_item_t o;
        if (!it.mode) begin
            coefs[it.coeff_index] = it.coeff_value;
            return;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = it.sample_in;
        p = clamp_val(up_f, MAX_UP);
        q = clamp_val(down_f, MAX_DOWN);
        t = clamp_val(taps_f, MAX_TAPS);
        if (grp_cnt + 1 < q) begin
            grp_cnt++;
            return;
        end
        grp_cnt = 0;
        for (int unsigned m = 0; m < p; m++) begin
            ph = (m * q) % p;
            j = (m * q) / p;
            pos = q - 1 - j;
            acc = 0;
            for (int unsigned h = ph; h < t; h += p) begin
                if (pos < HIST_DEPTH) acc += longint'(coefs[h]) * longint'(hist[pos]);
                pos++;
            end
            o.sample_out = round_sat16(acc);
            o.burst_last = (m + 1 == p);
            expected_outs.push_back(o);
        end
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                resample_item(s_data);
                void'(pending_items.pop_front());
            end
            if ((s_valid && !s_ready)) begin
            end else if (pending_items.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items[0];
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_outs.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected output: %0d last=%0b",
                                 m_data.sample_out, m_data.burst_last);
                end else begin
                    out_item_t e;
                    e = expected_outs.pop_front();
                    if (e.sample_out !== m_data.sample_out ||
                        e.burst_last !== m_data.burst_last) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: expected %0d/%0b got %0d/%0b",
                                     e.sample_out, e.burst_last,
                                     m_data.sample_out, m_data.burst_last);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT && !done) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val[8:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_UP_FACTOR:   up_f = val & 5'h1F;
            CFG_DOWN_FACTOR: down_f = val & 5'h1F;
            CFG_TAP_COUNT:   taps_f = val & 9'h1FF;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_outs.size() == 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic push_coef(input int idx, input logic signed [15:0] v);
        in_item_t it;
        it = '0;
        it.mode = 1'b0;
        it.coeff_index = idx[7:0];
        it.coeff_value = v;
        it.sample_in = 16'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_sample(input logic signed [15:0] v);
        in_item_t it;
        it.mode = 1'b1;
        it.coeff_index = 8'($urandom);
        it.coeff_value = 16'($urandom);
        it.sample_in = v;
        pending_items.push_back(it);
    endtask

    task automatic run_phase(input int unsigned p, input int unsigned q,
                             input int unsigned t, input int n_samples);
        write_reg(CFG_UP_FACTOR, p);
        write_reg(CFG_DOWN_FACTOR, q);
        write_reg(CFG_TAP_COUNT, t);
        for (int k = 0; k < n_samples; k++) begin
            if ($urandom_range(9) == 0) push_coef($urandom_range(255), 16'($urandom));
            else push_sample(16'($urandom));
        end
        drain();
    endtask

    initial begin
        logic [15:0] cv;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // load the coefficients in use first, extremes included
        for (int i = 0; i < COEF_LOADED; i++) begin
            cv = 16'($urandom);
            if (i == 0) cv = 16'h7FFF;
            if (i == 1) cv = 16'h8000;
            push_coef(i, cv);
        end
        drain();
        // directed: extremes, saturation, rounding
        write_reg(CFG_TAP_COUNT, 2);
        push_sample(16'sh7FFF); push_sample(16'sh8000);
        push_sample(16'sh8000); push_sample(16'sh0000);
        push_sample(16'sh0001); push_sample(16'shFFFF);
        drain();
        push_coef(0, 16'sh4000); push_coef(1, 16'sh0001);
        push_sample(16'sh0001); push_sample(16'shFFFF); push_sample(16'sh8000);
        drain();
        // out-of-range and boundary config values
        run_phase(0, 0, 0, 4);
        run_phase(31, 31, COEF_LOADED, 20);
        run_phase(16, 1, COEF_LOADED, 3);
        run_phase(1, 16, COEF_LOADED, 18);
        // Q lowered mid-group
        write_reg(CFG_UP_FACTOR, 3);
        write_reg(CFG_DOWN_FACTOR, 5);
        write_reg(CFG_TAP_COUNT, 9);
        push_sample(16'sh1234); push_sample(16'sh4321); push_sample(-16'sh0100);
        drain();
        run_phase(3, 2, 9, 5);
        // random phases with idling profiles
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 76) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 76) : 0;
            if (ph == 1) recv_stall_pct = 0;
            run_phase($urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(1, COEF_LOADED), 10);
        end
        send_idle_pct = 30;
        recv_stall_pct = 30;
        run_phase(5, 3, 48, 6);
        run_phase(2, 11, COEF_LOADED, 12);
        done = 1;
        if (errors == 0 && expected_outs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
